// ===== sv/iash_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iash_pkg;
    localparam int SeqLen   = 16;
    localparam int ModelDim = 32;
    localparam int PosW     = 4;
    localparam int DimW     = 5;
    localparam int AddrW    = PosW + DimW;
    localparam int Depth    = SeqLen * ModelDim;
    localparam logic [15:0] DecayQ15 = 16'd24149;
    localparam logic [3:0]  ExpFloor = 4'd15;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [3:0]        position;
        logic [4:0]        dim_index;
        logic signed [7:0] key_elem;
        logic signed [7:0] value_elem;
        logic signed [7:0] query_elem;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] context_val;
        logic [4:0]        context_dim;
        logic              row_last;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_IDLE  = 5'd0,
        OP_DOT   = 5'd1,
        OP_EXP   = 5'd2,
        OP_DIV   = 5'd3,
        OP_CTX   = 5'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       first;
        logic [5:0] j;
        logic [5:0] d;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;
endpackage
`default_nettype wire

// ===== sv/iash_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iash_ram #(
    parameter int Width = 8,
    parameter int Depth = 512
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/iash_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iash_dp import iash_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_wr,
    input  t_in_word   i_word,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output t_out_word  o_res
);
    // Pipeline: cmd -> registered RAM read -> compute with registered RAM data.
    logic [AddrW-1:0] raddr;
    logic signed [7:0] k_rd, v_rd;
    logic ld_we;
    logic signed [7:0] r_q [ModelDim];
    logic signed [15:0] r_score [SeqLen];
    logic [10:0] r_e [SeqLen];
    logic [15:0] r_w [SeqLen];
    t_cmd r_c1;
    logic signed [7:0] r_qd;
    logic signed [20:0] r_acc;
    logic signed [15:0] r_max;
    logic [14:0] r_sum;
    // exp unit
    logic [15:0] r_ev;
    logic [3:0] r_en;
    logic r_ebusy;
    // divider
    logic [4:0] r_dcnt;
    logic r_dbusy;
    logic [26:0] r_rem;
    logic [25:0] r_dnum;
    logic signed [23:0] r_cacc;
    t_out_word r_res;
    logic r_done;
    logic n_done;

    logic signed [20:0] dot_sum;
    logic signed [15:0] sc, diff;
    logic signed [16:0] sub;
    logic [3:0] nsh;
    logic [30:0] eprod;
    logic [27:0] rsh;
    logic signed [24:0] wv;
    logic signed [23:0] cnext;

    assign ld_we = i_wr && i_word.req_type == REQ_LOAD;
    assign raddr = {i_cmd.j[PosW-1:0], i_cmd.d[DimW-1:0]};

    iash_ram #(.Width(8), .Depth(Depth)) u_key (
        .i_clk(i_clk), .i_we(ld_we), .i_waddr({i_word.position, i_word.dim_index}),
        .i_wdata(i_word.key_elem), .i_raddr(raddr), .o_rdata(k_rd));
    iash_ram #(.Width(8), .Depth(Depth)) u_val (
        .i_clk(i_clk), .i_we(ld_we), .i_waddr({i_word.position, i_word.dim_index}),
        .i_wdata(i_word.value_elem), .i_raddr(raddr), .o_rdata(v_rd));

    assign dot_sum = (r_c1.first ? 21'sd0 : r_acc) + 21'(r_qd * k_rd);
    assign sc = 16'(dot_sum >>> 5);
    assign sub = 17'(r_score[r_c1.j[PosW-1:0]]) - 17'(r_max);
    always_comb begin
        diff = 16'(sub >>> 3);
        if (diff < -16'sd15) nsh = ExpFloor;
        else nsh = 4'(-diff);
    end
    assign eprod = r_ev * DecayQ15;
    assign rsh = {r_rem, r_dnum[25]} - {13'd0, r_sum};
    assign wv = $signed({1'b0, r_w[r_c1.j[PosW-1:0]]}) * v_rd;
    assign cnext = (r_c1.first ? 24'sd0 : r_cacc) + 24'(wv >>> 15);

    always_comb begin
        case (r_c1.op)
            OP_DOT:  n_done = r_c1.emit && r_c1.j == 6'(SeqLen - 1);
            OP_EXP:  n_done = !r_c1.first && r_ebusy && r_en == 4'd0;
            OP_DIV:  n_done = !r_c1.first && r_dbusy && r_dcnt == 5'd0;
            OP_CTX:  n_done = r_c1.emit;
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && i_word.req_type == REQ_QUERY) r_q[i_word.dim_index] <= i_word.query_elem;
        r_c1 <= i_cmd;
        r_qd <= r_q[i_cmd.d[DimW-1:0]];
        if (!i_rst_n) begin
            r_ebusy <= 1'b0; r_dbusy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= n_done;
            case (r_c1.op)
                OP_DOT: begin
                    r_acc <= dot_sum;
                    if (r_c1.emit) begin
                        r_score[r_c1.j[PosW-1:0]] <= sc;
                        if (r_c1.j == 6'd0 || sc > r_max) r_max <= sc;
                    end
                end
                OP_EXP: begin
                    if (r_c1.first) begin
                        r_ebusy <= 1'b1; r_ev <= 16'd32768; r_en <= nsh;
                        if (r_c1.j == 6'd0) r_sum <= 15'd0;
                    end else if (r_ebusy) begin
                        if (r_en != 4'd0) begin
                            r_ev <= eprod[30:15]; r_en <= r_en - 4'd1;
                        end else begin
                            r_ebusy <= 1'b0;
                            r_e[r_c1.j[PosW-1:0]] <= r_ev[15:5];
                            r_sum <= r_sum + 15'(r_ev[15:5]);
                        end
                    end
                end
                OP_DIV: begin
                    if (r_c1.first) begin
                        r_dbusy <= 1'b1; r_dcnt <= 5'd26;
                    end else if (r_dbusy) begin
                        if (r_dcnt != 5'd0) r_dcnt <= r_dcnt - 5'd1;
                        else r_dbusy <= 1'b0;
                    end
                end
                OP_CTX: begin
                    r_cacc <= cnext;
                    if (r_c1.emit) begin
                        r_res.context_dim <= r_c1.d[DimW-1:0];
                        r_res.row_last <= r_c1.d == 6'(ModelDim - 1);
                        r_res.context_val <= cnext > 24'sd127 ? 8'sd127 :
                            cnext < -24'sd128 ? -8'sd128 : 8'(cnext);
                    end
                end
                default: ;
            endcase
        end
    end

    // Restoring divider: quotient = (e<<15)/sum, 26 steps over r_rem.
    always_ff @(posedge i_clk) begin
        if (r_c1.op == OP_DIV) begin
            if (r_c1.first) begin
                r_rem <= 27'd0; r_dnum <= {r_e[r_c1.j[PosW-1:0]], 15'd0};
            end else if (r_dbusy && r_dcnt != 5'd0) begin
                r_dnum <= {r_dnum[24:0], 1'b0};
                if (!rsh[27]) begin
                    r_rem <= rsh[26:0]; r_w[r_c1.j[PosW-1:0]] <= {r_w[r_c1.j[PosW-1:0]][14:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[25:0], r_dnum[25]};
                    r_w[r_c1.j[PosW-1:0]] <= {r_w[r_c1.j[PosW-1:0]][14:0], 1'b0};
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== sv/iash_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iash_ctrl import iash_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  t_in_word   i_word,
    output logic       o_stall,
    output logic       o_wr,
    output t_cmd       o_cmd,
    input  t_sts       i_sts,
    output logic       o_valid,
    input  wire        i_stall
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_DOT = 6'b000010, S_EXP = 6'b000100,
        S_DIV  = 6'b001000, S_CTX = 6'b010000, S_OUT = 6'b100000
    } t_state;
    t_state r_st, n_st;
    logic [5:0] r_j, n_j, r_d, n_d;
    logic r_wait, n_wait, r_vld, n_vld;
    logic trig;

    assign o_stall = r_st != S_IDLE;
    assign o_wr = i_valid && !o_stall && 32'(i_word.dim_index) < ModelDim &&
        (i_word.req_type == REQ_QUERY || 32'(i_word.position) < SeqLen);
    assign trig = o_wr && i_word.req_type == REQ_QUERY &&
        32'(i_word.dim_index) == ModelDim - 1;
    assign o_valid = r_vld;

    always_comb begin
        n_st = r_st; n_j = r_j; n_d = r_d; n_wait = r_wait; n_vld = r_vld;
        o_cmd = '0;
        o_cmd.op = OP_IDLE;
        if (r_vld && !i_stall) n_vld = 1'b0;
        case (r_st)
            S_IDLE: if (trig) begin n_st = S_DOT; n_j = '0; n_d = '0; n_wait = 1'b0; end
            S_DOT: begin
                if (!r_wait) begin
                    o_cmd.op = OP_DOT; o_cmd.j = r_j; o_cmd.d = r_d;
                    o_cmd.first = r_d == 6'd0; o_cmd.emit = r_d == 6'(ModelDim - 1);
                    if (r_d == 6'(ModelDim - 1)) begin
                        n_d = '0;
                        if (r_j == 6'(SeqLen - 1)) n_wait = 1'b1; else n_j = r_j + 6'd1;
                    end else n_d = r_d + 6'd1;
                end else if (i_sts.done) begin n_wait = 1'b0; n_j = '0; n_st = S_EXP; end
            end
            S_EXP, S_DIV: begin
                o_cmd.op = r_st == S_EXP ? OP_EXP : OP_DIV; o_cmd.j = r_j;
                if (!r_wait) begin
                    o_cmd.first = 1'b1; n_wait = 1'b1;
                end else if (i_sts.done) begin
                    n_wait = 1'b0;
                    if (r_j == 6'(SeqLen - 1)) begin
                        n_j = '0; n_st = r_st == S_EXP ? S_DIV : S_CTX;
                    end else n_j = r_j + 6'd1;
                end
            end
            S_CTX: begin
                if (!r_wait) begin
                    o_cmd.op = OP_CTX; o_cmd.j = r_j; o_cmd.d = r_d;
                    o_cmd.first = r_j == 6'd0; o_cmd.emit = r_j == 6'(SeqLen - 1);
                    if (r_j == 6'(SeqLen - 1)) begin n_j = '0; n_wait = 1'b1; end
                    else n_j = r_j + 6'd1;
                end else if (i_sts.done) begin n_wait = 1'b0; n_vld = 1'b1; n_st = S_OUT; end
            end
            S_OUT: if (r_vld && !i_stall) begin
                if (r_d == 6'(ModelDim - 1)) n_st = S_IDLE;
                else begin n_d = r_d + 6'd1; n_st = S_CTX; end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_j <= '0; r_d <= '0; r_wait <= 1'b0; r_vld <= 1'b0;
        end else begin
            r_st <= n_st; r_j <= n_j; r_d <= n_d; r_wait <= n_wait; r_vld <= n_vld;
        end
    end
endmodule
`default_nettype wire

// ===== sv/int8_attention_head_softmax_top.sv =====
// Sequence: dot products for every position, then an exp step and a divide
// per position, then a context word per dimension, each computed after the previous one is accepted.
// Load and non-final query words are accepted while idle; the final query
// word starts a row, and o_stall stays high until its last context word is accepted.
// Reset: synchronous active-low i_rst_n clears control; stores are undefined.
`timescale 1ns / 1ps
`default_nettype none
module int8_attention_head_softmax_top import iash_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  t_in_word   i_data,
    output logic       o_valid,
    input  wire        i_stall,
    output t_out_word  o_data
);
    t_cmd cmd;
    t_sts sts;
    logic wr;
    iash_ctrl u_ctrl (.i_clk, .i_rst_n, .i_valid, .i_word(i_data), .o_stall,
        .o_wr(wr), .o_cmd(cmd), .i_sts(sts), .o_valid, .i_stall);
    iash_dp u_dp (.i_clk, .i_rst_n, .i_wr(wr), .i_word(i_data), .i_cmd(cmd),
        .o_sts(sts), .o_res(o_data));
endmodule
`default_nettype wire

// ===== sv/iash_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iash_chk import iash_pkg::*; (
    input wire i_clk, input wire i_rst_n, input wire i_valid, input wire o_stall,
    input wire o_valid, input wire i_stall, input t_out_word o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("hold");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("busy");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.row_last |-> o_data.context_dim == 5'(ModelDim - 1))
        else $error("last");
endmodule
bind int8_attention_head_softmax_top iash_chk u_chk (.*);
`default_nettype wire
